FILE: rtl/weighted_matrix_downsampler_defines.svh
// assertion helpers for the downsampler checker
`ifndef WEIGHTED_MATRIX_DOWNSAMPLER_DEFINES_SVH
`define WEIGHTED_MATRIX_DOWNSAMPLER_DEFINES_SVH

// property checked on every rising edge, masked while reset is high
`define WMD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising edge, reset included
`define WMD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/wmd_pkg.sv
`timescale 1ns / 1ps

package wmd_pkg;

  // field widths of the channels
  localparam int OP_W       = 2;
  localparam int COL_W      = 9;
  localparam int ROW_W      = 9;
  localparam int WIDX_W     = 6;
  localparam int WVAL_W     = 16;
  localparam int CH_W       = 16;
  localparam int OUT_CH     = 4;

  // register widths
  localparam int DIM_W      = 10;
  localparam int STEP_W     = 25;
  localparam int CCNT_W     = 3;
  localparam int KSIZE_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  // fixed point
  localparam int FRAC_W     = 16;
  localparam int WFRAC_W    = 12;
  localparam int MAG_W      = 16;

  typedef enum logic [OP_W-1:0] {
    OP_WEIGHT = 2'd0,
    OP_PIXEL  = 2'd1,
    OP_SAMPLE = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH     = 3'd0,
    REG_SRC_HEIGHT    = 3'd1,
    REG_STEP_X        = 3'd2,
    REG_STEP_Y        = 3'd3,
    REG_CHANNEL_COUNT = 3'd4,
    REG_KERNEL_SIZE   = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } wmd_state_t;

  // tap marker that travels down the read pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } tap_ctl_t;

endpackage

FILE: rtl/wmd_ifs.sv
`timescale 1ns / 1ps

// input item channel
interface wmd_item_if;
  import wmd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [COL_W-1:0]         col;
  logic [ROW_W-1:0]         row;
  logic [WIDX_W-1:0]        weight_index;
  logic signed [WVAL_W-1:0] weight_value;
  logic [CH_W-1:0]          in_ch0;
  logic [CH_W-1:0]          in_ch1;
  logic [CH_W-1:0]          in_ch2;
  logic [CH_W-1:0]          in_ch3;

  modport source (
    output valid, operation, col, row, weight_index, weight_value,
    output in_ch0, in_ch1, in_ch2, in_ch3,
    input  ready
  );
  modport sink (
    input  valid, operation, col, row, weight_index, weight_value,
    input  in_ch0, in_ch1, in_ch2, in_ch3,
    output ready
  );
endinterface

// result channel
interface wmd_result_if;
  import wmd_pkg::*;
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic [CH_W-1:0]  out_ch0;
  logic [CH_W-1:0]  out_ch1;
  logic [CH_W-1:0]  out_ch2;
  logic [CH_W-1:0]  out_ch3;

  modport source (
    output valid, out_col, out_row, out_ch0, out_ch1, out_ch2, out_ch3,
    input  ready
  );
  modport sink (
    input  valid, out_col, out_row, out_ch0, out_ch1, out_ch2, out_ch3,
    output ready
  );
endinterface

// configuration write channel
interface wmd_cfg_if;
  import wmd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/wmd_tap_seq.sv
`timescale 1ns / 1ps

module wmd_tap_seq #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int MAX_KERNEL = 6,
  localparam int XW  = $clog2(MAX_WIDTH),
  localparam int YW  = $clog2(MAX_HEIGHT),
  localparam int KW  = $clog2(MAX_KERNEL),
  localparam int TW  = $clog2(MAX_KERNEL * MAX_KERNEL),
  localparam int WLW = $clog2(MAX_WIDTH + 1),
  localparam int HLW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      issue,
  input  logic [wmd_pkg::COL_W-1:0]  col,
  input  logic [wmd_pkg::ROW_W-1:0]  row,
  input  logic [KW-1:0]              km1,
  input  logic [wmd_pkg::STEP_W-1:0] step_x,
  input  logic [wmd_pkg::STEP_W-1:0] step_y,
  input  logic [WLW-1:0]             w_lim,
  input  logic [HLW-1:0]             h_lim,
  output logic [TW-1:0]              tap,
  output logic                       issue_last,
  output wmd_pkg::tap_ctl_t          ctl,
  output logic [XW-1:0]              sx,
  output logic [YW-1:0]              sy
);
  import wmd_pkg::*;

  localparam int POSX_W  = COL_W + 1;
  localparam int POSY_W  = ROW_W + 1;
  localparam int PRODX_W = POSX_W + STEP_W;
  localparam int PRODY_W = POSY_W + STEP_W;
  localparam int CRDX_W  = PRODX_W - FRAC_W;
  localparam int CRDY_W  = PRODY_W - FRAC_W;

  logic [KW-1:0]      r_cnt;
  logic [KW-1:0]      c_cnt;
  logic [TW-1:0]      tap_cnt;
  logic [POSX_W-1:0]  pos_x;
  logic [POSY_W-1:0]  pos_y;
  tap_ctl_t           p_ctl;
  logic [PRODX_W-1:0] prod_x;
  logic [PRODY_W-1:0] prod_y;
  logic [CRDX_W-1:0]  vx;
  logic [CRDY_W-1:0]  vy;
  logic [XW-1:0]      sx_next;
  logic [YW-1:0]      sy_next;

  // tap walk, column of the weight matrix fastest
  always_ff @(posedge clk) begin
    if (rst) begin
      r_cnt   <= '0;
      c_cnt   <= '0;
      tap_cnt <= '0;
    end else if (start) begin
      r_cnt   <= '0;
      c_cnt   <= '0;
      tap_cnt <= '0;
    end else if (issue) begin
      if (c_cnt == km1) begin
        c_cnt <= '0;
        r_cnt <= r_cnt + KW'(1);
      end else begin
        c_cnt <= c_cnt + KW'(1);
      end
      tap_cnt <= tap_cnt + TW'(1);
    end
  end

  assign tap        = tap_cnt;
  assign issue_last = issue && (r_cnt == km1) && (c_cnt == km1);

  // kernel row moves the source column, kernel column moves the source row
  assign pos_x = POSX_W'(col) + POSX_W'(r_cnt);
  assign pos_y = POSY_W'(row) + POSY_W'(c_cnt);

  // scale stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_ctl <= '0;
    end else begin
      p_ctl.valid <= issue;
      p_ctl.last  <= issue_last;
    end
  end

  always_ff @(posedge clk) begin
    prod_x <= PRODX_W'(pos_x) * PRODX_W'(step_x);
    prod_y <= PRODY_W'(pos_y) * PRODY_W'(step_y);
  end

  // floor and clamp to the image
  assign vx = prod_x[PRODX_W-1:FRAC_W];
  assign vy = prod_y[PRODY_W-1:FRAC_W];

  always_comb begin
    if (vx >= CRDX_W'(w_lim)) begin
      sx_next = XW'(w_lim - WLW'(1));
    end else begin
      sx_next = XW'(vx);
    end
    if (vy >= CRDY_W'(h_lim)) begin
      sy_next = YW'(h_lim - HLW'(1));
    end else begin
      sy_next = YW'(vy);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= p_ctl;
    end
  end

  always_ff @(posedge clk) begin
    sx <= sx_next;
    sy <= sy_next;
  end

endmodule

FILE: rtl/wmd_lane.sv
`timescale 1ns / 1ps

module wmd_lane #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clear,
  input  logic                      valid,
  input  logic [PIXEL_BITS-1:0]     pix,
  input  logic [wmd_pkg::MAG_W-1:0] mag,
  output logic [PIXEL_BITS-1:0]     acc
);
  import wmd_pkg::*;

  localparam int PROD_W = PIXEL_BITS + MAG_W;

  logic [PROD_W-1:0]     full;
  logic [PIXEL_BITS-1:0] term;
  logic                  t_valid;

  // weighted tap, fraction dropped, only the kept bits survive
  assign full = PROD_W'(pix) * PROD_W'(mag);

  always_ff @(posedge clk) begin
    term <= full[WFRAC_W +: PIXEL_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else begin
      t_valid <= valid;
    end
  end

  // wrapping accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (clear) begin
      acc <= '0;
    end else if (t_valid) begin
      acc <= acc + term;
    end
  end

endmodule

FILE: rtl/weighted_matrix_downsampler.sv
// Weighted-kernel image downscaler. Three kinds of input transaction share one
// channel: a weight write stores a signed Q4.12 kernel weight, a pixel write
// stores one source pixel in the frame store, and a sample computes one output
// pixel from a KxK neighborhood and returns one result transaction. A sample
// occupies the block while it is accepted, for K*K tap reads, one per cycle
// because the frame store has a single read port, and while the pipeline
// carries its sum to the output register. One lane per channel does the
// multiply and accumulate; the output register holds a result until taken
// while the next transaction is already accepted. The frame store holds
// MAX_HEIGHT rows of 2^ceil(log2(MAX_WIDTH)) pixels; it and the weight memory
// power up undefined, are not cleared, and must be written before sampling.
`timescale 1ns / 1ps

module weighted_matrix_downsampler #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int MAX_KERNEL = 6,
  parameter int CHANNELS   = 4,
  parameter int PIXEL_BITS = 16
) (
  input logic          clk,
  input logic          rst,
  wmd_item_if.sink     items,
  wmd_result_if.source results,
  wmd_cfg_if.sink      cfg
);
  import wmd_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = MAX_HEIGHT * (1 << XW);
  localparam int KW    = $clog2(MAX_KERNEL);
  localparam int TAPS  = MAX_KERNEL * MAX_KERNEL;
  localparam int TW    = $clog2(TAPS);
  localparam int WLW   = $clog2(MAX_WIDTH + 1);
  localparam int HLW   = $clog2(MAX_HEIGHT + 1);
  localparam int NCW   = $clog2(CHANNELS + 1);
  localparam int PIXW  = CHANNELS * PIXEL_BITS;

  // configuration registers
  logic [DIM_W-1:0]   src_width;
  logic [DIM_W-1:0]   src_height;
  logic [STEP_W-1:0]  step_x;
  logic [STEP_W-1:0]  step_y;
  logic [CCNT_W-1:0]  channel_count;
  logic [KSIZE_W-1:0] kernel_size;

  logic [WLW-1:0] w_lim;
  logic [HLW-1:0] h_lim;
  logic [KW-1:0]  km1;
  logic [NCW-1:0] nch;

  wmd_state_t state;
  wmd_state_t state_next;
  logic       items_ready;
  logic       issue;
  logic       load_out;
  logic       item_fire;
  logic       sample_start;

  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;

  logic [CH_W-1:0] in_arr [OUT_CH];
  logic [PIXW-1:0] wr_pix;
  logic [XW-1:0]   wr_x;
  logic [YW-1:0]   wr_y;

  logic signed [WVAL_W-1:0] wt_mem [TAPS];
  logic [PIXW-1:0]          frame_mem [DEPTH];

  logic [TW-1:0] seq_tap;
  logic          seq_last;
  tap_ctl_t      seq_ctl;
  logic [XW-1:0] seq_sx;
  logic [YW-1:0] seq_sy;

  logic signed [WVAL_W-1:0] wt_rd;
  logic [MAG_W-1:0]         mag2;
  logic [MAG_W-1:0]         mag3;
  logic [PIXW-1:0]          pix3;
  tap_ctl_t                 ctl3;
  tap_ctl_t                 ctl4;
  logic                     done5;

  logic [PIXEL_BITS-1:0] lane_acc [CHANNELS];
  logic [CH_W-1:0]       merge_ch [OUT_CH];

  logic             out_valid;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic [CH_W-1:0]  out_ch [OUT_CH];

  // configuration writes, indexes beyond the list are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width     <= DIM_W'(512);
      src_height    <= DIM_W'(512);
      step_x        <= STEP_W'(65536);
      step_y        <= STEP_W'(65536);
      channel_count <= CCNT_W'(3);
      kernel_size   <= KSIZE_W'(2);
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_SRC_WIDTH:     src_width     <= cfg.data[DIM_W-1:0];
        REG_SRC_HEIGHT:    src_height    <= cfg.data[DIM_W-1:0];
        REG_STEP_X:        step_x        <= cfg.data[STEP_W-1:0];
        REG_STEP_Y:        step_y        <= cfg.data[STEP_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg.data[CCNT_W-1:0];
        REG_KERNEL_SIZE:   kernel_size   <= cfg.data[KSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate the registers into their legal ranges
  always_comb begin
    if (src_width == '0) begin
      w_lim = WLW'(1);
    end else if (int'(src_width) > MAX_WIDTH) begin
      w_lim = WLW'(MAX_WIDTH);
    end else begin
      w_lim = WLW'(src_width);
    end
    if (src_height == '0) begin
      h_lim = HLW'(1);
    end else if (int'(src_height) > MAX_HEIGHT) begin
      h_lim = HLW'(MAX_HEIGHT);
    end else begin
      h_lim = HLW'(src_height);
    end
    if (int'(kernel_size) < 2) begin
      km1 = KW'(1);
    end else if (int'(kernel_size) > MAX_KERNEL) begin
      km1 = KW'(MAX_KERNEL - 1);
    end else begin
      km1 = KW'(int'(kernel_size) - 1);
    end
    if (channel_count == '0) begin
      nch = NCW'(1);
    end else if (int'(channel_count) > CHANNELS) begin
      nch = NCW'(CHANNELS);
    end else begin
      nch = NCW'(channel_count);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (sample_start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (seq_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (done5) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // state outputs
  always_comb begin
    items_ready = 1'b0;
    issue       = 1'b0;
    load_out    = 1'b0;
    unique case (state)
      ST_IDLE:  items_ready = 1'b1;
      ST_RUN:   issue       = 1'b1;
      ST_DRAIN: ;
      ST_OUT:   load_out    = !out_valid || results.ready;
    endcase
  end

  assign items.ready  = items_ready;
  assign item_fire    = items.valid && items_ready;
  assign sample_start = item_fire && (items.operation == OP_SAMPLE);

  // sampled position, echoed in the result
  always_ff @(posedge clk) begin
    if (sample_start) begin
      col_q <= items.col;
      row_q <= items.row;
    end
  end

  // weight memory
  always_ff @(posedge clk) begin
    if (item_fire && (items.operation == OP_WEIGHT) && (int'(items.weight_index) < TAPS)) begin
      wt_mem[TW'(items.weight_index)] <= items.weight_value;
    end
  end

  always_ff @(posedge clk) begin
    wt_rd <= wt_mem[seq_tap];
  end

  // frame store write data and address
  assign in_arr[0] = items.in_ch0;
  assign in_arr[1] = items.in_ch1;
  assign in_arr[2] = items.in_ch2;
  assign in_arr[3] = items.in_ch3;
  assign wr_x      = XW'(items.col);
  assign wr_y      = YW'(items.row);

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      wr_pix[ch*PIXEL_BITS +: PIXEL_BITS] = in_arr[ch][PIXEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire && (items.operation == OP_PIXEL) &&
        (int'(items.col) < MAX_WIDTH) && (int'(items.row) < MAX_HEIGHT)) begin
      frame_mem[{wr_y, wr_x}] <= wr_pix;
    end
  end

  // tap sequencer with coordinate scaling
  wmd_tap_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_tap_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (sample_start),
    .issue      (issue),
    .col        (col_q),
    .row        (row_q),
    .km1        (km1),
    .step_x     (step_x),
    .step_y     (step_y),
    .w_lim      (w_lim),
    .h_lim      (h_lim),
    .tap        (seq_tap),
    .issue_last (seq_last),
    .ctl        (seq_ctl),
    .sx         (seq_sx),
    .sy         (seq_sy)
  );

  // weight magnitude, lined up with the clamped coordinates
  always_ff @(posedge clk) begin
    mag2 <= wt_rd[WVAL_W-1] ? MAG_W'(-wt_rd) : MAG_W'(wt_rd);
  end

  // frame store read
  always_ff @(posedge clk) begin
    pix3 <= frame_mem[AW'({seq_sy, seq_sx})];
    mag3 <= mag2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3  <= '0;
      ctl4  <= '0;
      done5 <= 1'b0;
    end else begin
      ctl3  <= seq_ctl;
      ctl4  <= ctl3;
      done5 <= ctl4.valid && ctl4.last;
    end
  end

  // one multiply-accumulate lane per channel
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    wmd_lane #(
      .PIXEL_BITS (PIXEL_BITS)
    ) u_lane (
      .clk   (clk),
      .rst   (rst),
      .clear (sample_start),
      .valid (ctl3.valid),
      .pix   (pix3[g*PIXEL_BITS +: PIXEL_BITS]),
      .mag   (mag3),
      .acc   (lane_acc[g])
    );
  end

  // merge lanes, channels beyond the used count read zero
  for (genvar g = 0; g < OUT_CH; g++) begin : g_merge
    if (g < CHANNELS) begin : g_used
      assign merge_ch[g] = (NCW'(g) < nch) ? CH_W'(lane_acc[g]) : '0;
    end else begin : g_absent
      assign merge_ch[g] = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_col <= col_q;
      out_row <= row_q;
      for (int ch = 0; ch < OUT_CH; ch++) begin
        out_ch[ch] <= merge_ch[ch];
      end
    end
  end

  assign results.valid   = out_valid;
  assign results.out_col = out_col;
  assign results.out_row = out_row;
  assign results.out_ch0 = out_ch[0];
  assign results.out_ch1 = out_ch[1];
  assign results.out_ch2 = out_ch[2];
  assign results.out_ch3 = out_ch[3];

endmodule

FILE: rtl/wmd_checker.sv
`timescale 1ns / 1ps
`include "weighted_matrix_downsampler_defines.svh"

module wmd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      item_valid,
  input logic                      item_ready,
  input logic [wmd_pkg::OP_W-1:0]  item_op,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic [wmd_pkg::COL_W-1:0] res_col,
  input logic [wmd_pkg::ROW_W-1:0] res_row,
  input logic [wmd_pkg::CH_W-1:0]  res_ch0,
  input logic [wmd_pkg::CH_W-1:0]  res_ch1,
  input logic [wmd_pkg::CH_W-1:0]  res_ch2,
  input logic [wmd_pkg::CH_W-1:0]  res_ch3
);
  import wmd_pkg::*;

  // a stalled result keeps its payload
  `WMD_ASSERT(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res_col) && $stable(res_row) && $stable(res_ch0) && $stable(res_ch1) && $stable(res_ch2) && $stable(res_ch3), "result changed while stalled")

  // reset empties the output register
  `WMD_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !res_valid, "result valid after reset")

  // a sample transaction blocks the input until its result is formed
  `WMD_ASSERT(a_sample_busy, clk, rst, item_valid && item_ready && (item_op == OP_SAMPLE) |=> !item_ready, "input open during a sample")

  // writes never block the input
  `WMD_ASSERT(a_write_open, clk, rst, item_valid && item_ready && (item_op != OP_SAMPLE) |=> item_ready, "input closed after a write")

  // a new result only follows a busy period
  `WMD_ASSERT(a_res_source, clk, rst, $rose(res_valid) |-> $past(!item_ready), "result appeared without a sample")

endmodule

bind weighted_matrix_downsampler wmd_checker u_wmd_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (items.valid),
  .item_ready (items.ready),
  .item_op    (items.operation),
  .res_valid  (results.valid),
  .res_ready  (results.ready),
  .res_col    (results.out_col),
  .res_row    (results.out_row),
  .res_ch0    (results.out_ch0),
  .res_ch1    (results.out_ch1),
  .res_ch2    (results.out_ch2),
  .res_ch3    (results.out_ch3)
);
